// ===== sv/uct_pkg.sv =====
// ----------------------------------------------------------------------------
// uct_pkg
// Shared types, byte codes and role codes for the URL component tagger.
// ----------------------------------------------------------------------------
package uct_pkg;

   // Byte codes the parser reacts to
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_QUERY  = 8'h3F;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_EQUALS = 8'h3D;

   // Byte roles
   localparam logic [3:0] ROLE_SCHEME = 4'd0;
   localparam logic [3:0] ROLE_DELIM  = 4'd1;
   localparam logic [3:0] ROLE_HOST   = 4'd2;
   localparam logic [3:0] ROLE_COLON  = 4'd3;
   localparam logic [3:0] ROLE_PORT   = 4'd4;
   localparam logic [3:0] ROLE_PATH   = 4'd5;
   localparam logic [3:0] ROLE_QUERY  = 4'd6;
   localparam logic [3:0] ROLE_NAME   = 4'd7;
   localparam logic [3:0] ROLE_EQUALS = 4'd8;
   localparam logic [3:0] ROLE_VALUE  = 4'd9;
   localparam logic [3:0] ROLE_AMP    = 4'd10;

   // Error codes on the final item of a URL
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_EMPTY    = 2'd1;
   localparam logic [1:0] ERR_NO_DELIM = 2'd2;

   // Bytes held back while looking for "://"
   localparam logic [1:0] HELD_NONE        = 2'd0;
   localparam logic [1:0] HELD_COLON       = 2'd1;
   localparam logic [1:0] HELD_COLON_SLASH = 2'd2;

   // Most result items one input item can cause
   localparam int unsigned MAX_RESULTS = 3;
   // Slots in the result queue
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [6:0] {
      PH_START  = 7'b0000001,
      PH_SCHEME = 7'b0000010,
      PH_HOST   = 7'b0000100,
      PH_PORT   = 7'b0001000,
      PH_PATH   = 7'b0010000,
      PH_NAME   = 7'b0100000,
      PH_VALUE  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       has_char;
      logic [7:0] char_in;
      logic       last;
   } req_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] byte_out;
      logic [3:0] role;
      logic       end_of_url;
      logic [1:0] error;
   } result_type;

   // Results of one input item, in order, slot 0 first
   typedef struct packed {
      logic                               valid;
      logic [1:0]                         count;
      result_type [MAX_RESULTS-1:0]       items;
   } batch_type;

   function automatic result_type item_of(input logic [7:0] b, input logic [3:0] r);
      result_type item;
      item.has_byte   = 1'b1;
      item.byte_out   = b;
      item.role       = r;
      item.end_of_url = 1'b0;
      item.error      = ERR_NONE;
      return item;
   endfunction

endpackage

// ===== sv/uct_req_if.sv =====
// ----------------------------------------------------------------------------
// uct_req_if
// Input channel: one URL byte and end marker per item.
// ----------------------------------------------------------------------------
interface uct_req_if;
   logic       valid;
   logic       ready;
   logic       has_char;
   logic [7:0] char_in;
   logic       last;

   modport source (output valid, output has_char, output char_in, output last,
                   input ready);
   modport sink   (input valid, input has_char, input char_in, input last,
                   output ready);
endinterface

// ===== sv/uct_rsp_if.sv =====
// ----------------------------------------------------------------------------
// uct_rsp_if
// Result channel: one tagged byte per item.
// ----------------------------------------------------------------------------
interface uct_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] byte_out;
   logic [3:0] role;
   logic       end_of_url;
   logic [1:0] error;

   modport source (output valid, output has_byte, output byte_out, output role,
                   output end_of_url, output error, input ready);
   modport sink   (input valid, input has_byte, input byte_out, input role,
                   input end_of_url, input error, output ready);
endinterface

// ===== sv/uct_tagger.sv =====
// ----------------------------------------------------------------------------
// uct_tagger
// Input register, parse state and the per-byte tagging logic. Produces up to
// three result items per input item, handed to the queue when it has room.
// ----------------------------------------------------------------------------
module uct_tagger (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  uct_pkg::req_type    req_data,
   output logic                req_ready,
   input  logic                room,
   output uct_pkg::batch_type  batch
);

   logic                 in_vld_ff, in_vld_in;
   uct_pkg::req_type     in_ff, in_in;
   uct_pkg::phase_type   phase_ff, phase_in;
   logic [1:0]           held_ff, held_in;
   logic                 seen_ff, seen_in;

   logic                 advance;
   uct_pkg::phase_type   ph;
   logic [1:0]           hc;
   logic                 seen;
   logic                 done;
   logic [1:0]           n;
   logic [1:0]           err;
   logic [7:0]           c;
   uct_pkg::result_type [uct_pkg::MAX_RESULTS-1:0] items;

   assign advance   = in_vld_ff && room;
   assign req_ready = !in_vld_ff || room;

   always_comb begin
      in_vld_in = in_vld_ff;
      in_in     = in_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
         in_in     = req_data;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      ph    = phase_ff;
      hc    = held_ff;
      seen  = seen_ff;
      done  = 1'b0;
      n     = 2'd0;
      err   = uct_pkg::ERR_NONE;
      c     = in_ff.char_in;
      items = '0;

      if (in_ff.has_char) begin
         if (ph == uct_pkg::PH_START) begin
            seen = 1'b1;
            if (c == uct_pkg::CH_SLASH) begin
               ph = uct_pkg::PH_PATH;
               items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_PATH);
               n = n + 2'd1;
               done = 1'b1;
            end else begin
               ph = uct_pkg::PH_SCHEME;
               hc = uct_pkg::HELD_NONE;
            end
         end
         if (!done) begin
            case (ph)
               uct_pkg::PH_SCHEME: begin
                  // flush held bytes that did not become "://"
                  if (hc == uct_pkg::HELD_COLON && c != uct_pkg::CH_SLASH) begin
                     items[n] = uct_pkg::item_of(uct_pkg::CH_COLON, uct_pkg::ROLE_SCHEME);
                     n = n + 2'd1;
                     hc = uct_pkg::HELD_NONE;
                  end else if (hc == uct_pkg::HELD_COLON) begin
                     hc = uct_pkg::HELD_COLON_SLASH;
                     done = 1'b1;
                  end else if (hc == uct_pkg::HELD_COLON_SLASH
                               && c == uct_pkg::CH_SLASH) begin
                     items[0] = uct_pkg::item_of(uct_pkg::CH_COLON, uct_pkg::ROLE_DELIM);
                     items[1] = uct_pkg::item_of(uct_pkg::CH_SLASH, uct_pkg::ROLE_DELIM);
                     items[2] = uct_pkg::item_of(uct_pkg::CH_SLASH, uct_pkg::ROLE_DELIM);
                     n = 2'd3;
                     hc = uct_pkg::HELD_NONE;
                     ph = uct_pkg::PH_HOST;
                     done = 1'b1;
                  end else if (hc == uct_pkg::HELD_COLON_SLASH) begin
                     items[0] = uct_pkg::item_of(uct_pkg::CH_COLON, uct_pkg::ROLE_SCHEME);
                     items[1] = uct_pkg::item_of(uct_pkg::CH_SLASH, uct_pkg::ROLE_SCHEME);
                     n = 2'd2;
                     hc = uct_pkg::HELD_NONE;
                  end
                  if (!done) begin
                     if (c == uct_pkg::CH_COLON) begin
                        hc = uct_pkg::HELD_COLON;
                     end else begin
                        items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_SCHEME);
                        n = n + 2'd1;
                     end
                  end
               end
               uct_pkg::PH_HOST: begin
                  if (c == uct_pkg::CH_SLASH) begin
                     ph = uct_pkg::PH_PATH;
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_PATH);
                  end else if (c == uct_pkg::CH_COLON) begin
                     ph = uct_pkg::PH_PORT;
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_COLON);
                  end else begin
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_HOST);
                  end
                  n = n + 2'd1;
               end
               uct_pkg::PH_PORT: begin
                  if (c == uct_pkg::CH_SLASH) begin
                     ph = uct_pkg::PH_PATH;
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_PATH);
                  end else begin
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_PORT);
                  end
                  n = n + 2'd1;
               end
               uct_pkg::PH_PATH: begin
                  if (c == uct_pkg::CH_QUERY) begin
                     ph = uct_pkg::PH_NAME;
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_QUERY);
                  end else begin
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_PATH);
                  end
                  n = n + 2'd1;
               end
               uct_pkg::PH_NAME: begin
                  if (c == uct_pkg::CH_EQUALS) begin
                     ph = uct_pkg::PH_VALUE;
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_EQUALS);
                  end else if (c == uct_pkg::CH_AMP) begin
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_AMP);
                  end else begin
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_NAME);
                  end
                  n = n + 2'd1;
               end
               default: begin
                  if (c == uct_pkg::CH_AMP) begin
                     ph = uct_pkg::PH_NAME;
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_AMP);
                  end else begin
                     ph = uct_pkg::PH_VALUE;
                     items[n] = uct_pkg::item_of(c, uct_pkg::ROLE_VALUE);
                  end
                  n = n + 2'd1;
               end
            endcase
         end
      end

      if (in_ff.last) begin
         if (!seen || ph == uct_pkg::PH_START) begin
            err = uct_pkg::ERR_EMPTY;
         end else if (ph == uct_pkg::PH_SCHEME) begin
            err = uct_pkg::ERR_NO_DELIM;
            if (hc != uct_pkg::HELD_NONE) begin
               items[n] = uct_pkg::item_of(uct_pkg::CH_COLON, uct_pkg::ROLE_SCHEME);
               n = n + 2'd1;
            end
            if (hc == uct_pkg::HELD_COLON_SLASH) begin
               items[n] = uct_pkg::item_of(uct_pkg::CH_SLASH, uct_pkg::ROLE_SCHEME);
               n = n + 2'd1;
            end
         end
         // bare end marker item when nothing else goes out
         if (n == 2'd0) begin
            n = 2'd1;
         end
         items[n - 2'd1].end_of_url = 1'b1;
         items[n - 2'd1].error      = err;
         ph   = uct_pkg::PH_START;
         hc   = uct_pkg::HELD_NONE;
         seen = 1'b0;
      end
   end

   assign phase_in = advance ? ph   : phase_ff;
   assign held_in  = advance ? hc   : held_ff;
   assign seen_in  = advance ? seen : seen_ff;

   assign batch.valid = advance;
   assign batch.count = n;
   assign batch.items = items;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         phase_ff  <= uct_pkg::PH_START;
         held_ff   <= uct_pkg::HELD_NONE;
         seen_ff   <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         seen_ff   <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

endmodule

// ===== sv/uct_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// uct_rsp_queue
// Four-slot result queue. Takes a batch of up to three items in one cycle and
// presents one item a cycle from slot 0 while out_ready is high.
// ----------------------------------------------------------------------------
module uct_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  uct_pkg::batch_type   batch,
   output logic                 room,
   output logic                 out_valid,
   output uct_pkg::result_type  out_item,
   input  logic                 out_ready
);

   uct_pkg::result_type [uct_pkg::QUEUE_DEPTH-1:0] q_ff, q_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;
   logic [2:0]  base;

   assign out_valid = (count_ff != 3'd0);
   assign out_item  = q_ff[0];
   assign pop       = out_valid && out_ready;
   assign base      = count_ff - {2'b00, pop};
   // a full batch always fits once at most one item is left
   assign room      = (base <= 3'd1);

   always_comb begin
      q_in     = q_ff;
      count_in = base;
      if (pop) begin
         for (int j = 0; j < uct_pkg::QUEUE_DEPTH - 1; j++) begin
            q_in[j] = q_ff[j + 1];
         end
      end
      if (batch.valid) begin
         for (int i = 0; i < uct_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < batch.count) begin
               q_in[base[1:0] + 2'(i)] = batch.items[i];
            end
         end
         count_in = base + {1'b0, batch.count};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

// ===== sv/url_component_tagger.sv =====
// ----------------------------------------------------------------------------
// url_component_tagger
// Tags each byte of a URL with its role (scheme, delimiter, host, port, path,
// query and parameter parts) and flags the end of each URL with an error code.
// ----------------------------------------------------------------------------
//
//   channel   direction   carries
//   req_chan  in          has_char, char_in, last: one URL byte per item
//   rsp_chan  out         has_byte, byte_out, role, end_of_url, error
//
// One input item is taken per cycle while the input register can take it; each
// tagged byte leaves as one item per cycle while the result channel is ready,
// so an input item that releases held "://" bytes or a flushed scheme yields
// up to three output items. Each accepted item passes through the input
// register, then the four-slot result queue, on its way to the result channel.
// Synchronous reset returns parse state to the start of a URL and empties the
// queue. A stalled result channel fills the queue; input stalls only while the
// input register is full and two or more items would stay in the queue after
// this cycle's pop.
// ----------------------------------------------------------------------------
module url_component_tagger (
   input  logic          clock,
   input  logic          reset,
   uct_req_if.sink       req_chan,
   uct_rsp_if.source     rsp_chan
);

   uct_pkg::req_type     req_data;
   uct_pkg::batch_type   batch;
   uct_pkg::result_type  out_item;
   logic                 room;

   assign req_data.has_char = req_chan.has_char;
   assign req_data.char_in  = req_chan.char_in;
   assign req_data.last     = req_chan.last;

   uct_tagger u_tagger (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_data  (req_data),
      .req_ready (req_chan.ready),
      .room      (room),
      .batch     (batch)
   );

   uct_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_item  (out_item),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.has_byte   = out_item.has_byte;
   assign rsp_chan.byte_out   = out_item.byte_out;
   assign rsp_chan.role       = out_item.role;
   assign rsp_chan.end_of_url = out_item.end_of_url;
   assign rsp_chan.error      = out_item.error;

endmodule

// ===== bench/url_component_tagger_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_component_tagger_tb
// Self-checking bench for the URL component tagger. A queue of URL bytes
// (directed cases, then random well-formed and malformed URLs) feeds a burst
// driver. Each accepted item is run through a behavioural tagger, and the
// tags it predicts are checked in order against the result channel, which
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module url_component_tagger_tb;
   import uct_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned RANDOM_ITEMS = 330;
   localparam int unsigned MAX_REPORTS  = 20;

   // kinds of random URL
   localparam int KIND_NOISE   = 0;
   localparam int KIND_ROOTED  = 1;
   localparam int KIND_BROKEN  = 2;
   localparam int KIND_EMPTY   = 3;
   localparam int KIND_LAST    = 9;

   // receiver stall patterns
   localparam int RX_ALWAYS = 0;
   localparam int RX_COIN   = 1;
   localparam int RX_BURSTY = 2;
   localparam int RX_THIRD  = 3;

   logic clock;
   logic reset;

   uct_req_if req_if ();
   uct_rsp_if rsp_if ();

   url_component_tagger dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Behavioural tagger
   // ---------------------------------------------------------------------
   phase_type  url_phase;
   logic [1:0] held;
   logic       seen_byte;

   result_type step_tags[$];
   result_type expected_tags[$];

   int unsigned urls_ended;
   int unsigned tags_checked;
   int unsigned role_hits[11];
   int unsigned err_hits[3];
   int unsigned mismatches;

   function automatic void emit_tag(input logic [7:0] b, input logic [3:0] r);
      result_type t;
      if (step_tags.size() >= MAX_RESULTS) return;
      t.has_byte   = 1'b1;
      t.byte_out   = b;
      t.role       = r;
      t.end_of_url = 1'b0;
      t.error      = ERR_NONE;
      step_tags.insert(step_tags.size(), t);
   endfunction

   function automatic void scan_scheme(input logic [7:0] c);
      if (c == CH_COLON) held = HELD_COLON;
      else emit_tag(c, ROLE_SCHEME);
   endfunction

   function automatic void tag_byte(input logic [7:0] c);
      if (url_phase == PH_START) begin
         seen_byte = 1'b1;
         if (c == CH_SLASH) begin
            url_phase = PH_PATH;
            emit_tag(c, ROLE_PATH);
            return;
         end
         url_phase = PH_SCHEME;
         held      = HELD_NONE;
      end
      case (url_phase)
         PH_SCHEME: begin
            if (held == HELD_NONE) begin
               scan_scheme(c);
            end else if (held == HELD_COLON) begin
               if (c == CH_SLASH) begin
                  held = HELD_COLON_SLASH;
               end else begin
                  emit_tag(CH_COLON, ROLE_SCHEME);
                  held = HELD_NONE;
                  scan_scheme(c);
               end
            end else if (c == CH_SLASH) begin
               emit_tag(CH_COLON, ROLE_DELIM);
               emit_tag(CH_SLASH, ROLE_DELIM);
               emit_tag(CH_SLASH, ROLE_DELIM);
               held      = HELD_NONE;
               url_phase = PH_HOST;
            end else begin
               emit_tag(CH_COLON, ROLE_SCHEME);
               emit_tag(CH_SLASH, ROLE_SCHEME);
               held = HELD_NONE;
               scan_scheme(c);
            end
         end
         PH_HOST: begin
            if (c == CH_SLASH) begin
               url_phase = PH_PATH;
               emit_tag(c, ROLE_PATH);
            end else if (c == CH_COLON) begin
               url_phase = PH_PORT;
               emit_tag(c, ROLE_COLON);
            end else begin
               emit_tag(c, ROLE_HOST);
            end
         end
         PH_PORT: begin
            if (c == CH_SLASH) begin
               url_phase = PH_PATH;
               emit_tag(c, ROLE_PATH);
            end else begin
               emit_tag(c, ROLE_PORT);
            end
         end
         PH_PATH: begin
            if (c == CH_QUERY) begin
               url_phase = PH_NAME;
               emit_tag(c, ROLE_QUERY);
            end else begin
               emit_tag(c, ROLE_PATH);
            end
         end
         PH_NAME: begin
            if (c == CH_EQUALS) begin
               url_phase = PH_VALUE;
               emit_tag(c, ROLE_EQUALS);
            end else if (c == CH_AMP) begin
               emit_tag(c, ROLE_AMP);
            end else begin
               emit_tag(c, ROLE_NAME);
            end
         end
         default: begin
            if (c == CH_AMP) begin
               url_phase = PH_NAME;
               emit_tag(c, ROLE_AMP);
            end else begin
               url_phase = PH_VALUE;
               emit_tag(c, ROLE_VALUE);
            end
         end
      endcase
   endfunction

   function automatic void predict_tags(input logic hc, input logic [7:0] c,
                                        input logic lst);
      logic [1:0] err;
      result_type t;
      step_tags.delete();
      err = ERR_NONE;
      if (hc) tag_byte(c);
      if (lst) begin
         if (!seen_byte || url_phase == PH_START) begin
            err = ERR_EMPTY;
         end else if (url_phase == PH_SCHEME) begin
            // URL ended inside the scheme: flush whatever is held
            err = ERR_NO_DELIM;
            if (held >= HELD_COLON) emit_tag(CH_COLON, ROLE_SCHEME);
            if (held >= HELD_COLON_SLASH) emit_tag(CH_SLASH, ROLE_SCHEME);
         end
         if (step_tags.size() == 0) begin
            t = '0;
            step_tags.insert(step_tags.size(), t);
         end
         t = step_tags[step_tags.size()-1];
         t.end_of_url = 1'b1;
         t.error      = err;
         step_tags[step_tags.size()-1] = t;
         url_phase  = PH_START;
         held       = HELD_NONE;
         seen_byte  = 1'b0;
         urls_ended++;
         err_hits[err]++;
      end
      foreach (step_tags[i]) begin
         expected_tags.insert(expected_tags.size(), step_tags[i]);
         if (step_tags[i].has_byte) role_hits[step_tags[i].role]++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus store
   // ---------------------------------------------------------------------
   req_type     pending[$];
   logic [7:0]  url_buf[$];
   int unsigned stim_items;

   task automatic add_item(input logic hc, input logic [7:0] c, input logic lst);
      req_type r;
      r.has_char = hc;
      r.char_in  = c;
      r.last     = lst;
      pending.insert(pending.size(), r);
      if (hc || lst) stim_items++;
   endtask

   task automatic add_text(input string s, input bit end_here);
      for (int i = 0; i < s.len(); i++)
         add_item(1'b1, s[i], end_here && (i == s.len() - 1));
   endtask

   function automatic void add_byte(input logic [7:0] b);
      url_buf.insert(url_buf.size(), b);
   endfunction

   // Sends url_buf, with the odd idle item mixed in, and closes the URL
   task automatic flush_url();
      bit on_byte;
      on_byte = 1'($urandom_range(0, 1));
      foreach (url_buf[i]) begin
         if ($urandom_range(0, 11) == 0)
            add_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
         add_item(1'b1, url_buf[i], on_byte && (i == url_buf.size() - 1));
      end
      if (!on_byte || url_buf.size() == 0)
         add_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
      url_buf.delete();
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CH_COLON || b == CH_SLASH || b == CH_QUERY || b == CH_AMP || b == CH_EQUALS)
         b = 8'h61 + b[3:0];
      return b;
   endfunction

   function automatic logic [7:0] pick_byte(input logic [7:0] special);
      return ($urandom_range(0, 3) == 0) ? special : plain_byte();
   endfunction

   task automatic gen_url();
      int kind;
      int n;
      int params;
      kind = $urandom_range(0, KIND_LAST);
      case (kind)
         KIND_NOISE: begin
            n = $urandom_range(1, 6);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
         end
         KIND_ROOTED: begin
            add_byte(CH_SLASH);
            n = $urandom_range(0, 6);
            repeat (n) begin
               case ($urandom_range(0, 4))
                  0: add_byte(CH_QUERY);
                  1: add_byte(CH_AMP);
                  2: add_byte(CH_EQUALS);
                  3: add_byte(CH_SLASH);
                  default: add_byte(plain_byte());
               endcase
            end
         end
         KIND_BROKEN: begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0: add_byte(CH_COLON);
                  1: add_byte(CH_SLASH);
                  default: add_byte(plain_byte());
               endcase
            end
         end
         KIND_EMPTY: begin
            if ($urandom_range(0, 1)) add_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
         end
         default: begin
            n = $urandom_range(0, 4);
            repeat (n) add_byte(plain_byte());
            add_byte(CH_COLON);
            add_byte(CH_SLASH);
            add_byte(CH_SLASH);
            n = $urandom_range(0, 4);
            repeat (n) add_byte(plain_byte());
            if ($urandom_range(0, 1)) begin
               add_byte(CH_COLON);
               n = $urandom_range(0, 3);
               repeat (n) add_byte(pick_byte(CH_COLON));
            end
            if ($urandom_range(0, 3) != 0) begin
               add_byte(CH_SLASH);
               n = $urandom_range(0, 4);
               repeat (n) add_byte(pick_byte(CH_SLASH));
               if ($urandom_range(0, 2) != 0) begin
                  add_byte(CH_QUERY);
                  params = $urandom_range(0, 3);
                  for (int p = 0; p < params; p++) begin
                     if (p > 0) add_byte(CH_AMP);
                     n = $urandom_range(0, 3);
                     repeat (n) add_byte(plain_byte());
                     if ($urandom_range(0, 3) != 0) begin
                        add_byte(CH_EQUALS);
                        n = $urandom_range(0, 3);
                        repeat (n) add_byte(pick_byte(CH_EQUALS));
                     end
                  end
               end
            end
         end
      endcase
      flush_url();
   endtask

   // ---------------------------------------------------------------------
   // Driver: bursts of random length with random gaps
   // ---------------------------------------------------------------------
   int unsigned burst_left;
   int unsigned gap_left;
   req_type     next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            predict_tags(req_if.has_char, req_if.char_in, req_if.last);
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending.size() > 0) begin
               next_req = pending.pop_front();
               req_if.valid    <= 1'b1;
               req_if.has_char <= next_req.has_char;
               req_if.char_in  <= next_req.char_in;
               req_if.last     <= next_req.last;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver stall pattern and result checker
   // ---------------------------------------------------------------------
   int unsigned rx_cycle;
   int          rx_mode;
   int unsigned rx_hold;
   result_type  got_tag;
   result_type  want_tag;

   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = $urandom_range(RX_ALWAYS, RX_THIRD);
      case (rx_mode)
         RX_ALWAYS: rsp_if.ready <= 1'b1;
         RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
         RX_BURSTY: begin
            if (rx_hold > 0) begin
               rx_hold--;
               rsp_if.ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               rx_hold = $urandom_range(3, 12);
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
         default: rsp_if.ready <= (rx_cycle % 3 == 0);
      endcase

      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_tag.has_byte   = rsp_if.has_byte;
         got_tag.byte_out   = rsp_if.byte_out;
         got_tag.role       = rsp_if.role;
         got_tag.end_of_url = rsp_if.end_of_url;
         got_tag.error      = rsp_if.error;
         if (expected_tags.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected item has_byte=%0b byte=%02h role=%0d eou=%0b err=%0d",
                        $time, got_tag.has_byte, got_tag.byte_out, got_tag.role,
                        got_tag.end_of_url, got_tag.error);
         end else begin
            want_tag = expected_tags.pop_front();
            tags_checked++;
            if (got_tag !== want_tag) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"%0t: mismatch exp has_byte=%0b byte=%02h role=%0d eou=%0b err=%0d",
                            " | got has_byte=%0b byte=%02h role=%0d eou=%0b err=%0d"},
                           $time, want_tag.has_byte, want_tag.byte_out, want_tag.role,
                           want_tag.end_of_url, want_tag.error, got_tag.has_byte,
                           got_tag.byte_out, got_tag.role, got_tag.end_of_url,
                           got_tag.error);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------
   int unsigned cycle_count;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d items still pending, %0d tags outstanding",
                  $time, pending.size(), expected_tags.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   int unsigned directed_items;

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.has_char = 1'b0;
      req_if.char_in  = 8'h00;
      req_if.last     = 1'b0;
      rsp_if.ready    = 1'b0;
      url_phase       = PH_START;
      held            = HELD_NONE;
      seen_byte       = 1'b0;
      rx_mode         = RX_ALWAYS;

      // empty URL
      add_item(1'b0, 8'h00, 1'b1);
      // every role, including empty parameters at the end
      add_text("h://x:8/p?n=v&&", 1'b1);
      // rooted URL with top byte and an idle item in the middle
      add_item(1'b1, CH_SLASH, 1'b0);
      add_item(1'b0, 8'hA5, 1'b0);
      add_item(1'b1, 8'hFF, 1'b1);
      // no delimiter, ":/" held when the end marker comes
      add_item(1'b1, 8'h00, 1'b0);
      add_text(":/", 1'b0);
      add_item(1'b0, 8'h00, 1'b1);
      // held ":/" broken by a colon on the final byte: three tags at once
      add_text(":/:", 1'b1);
      directed_items = stim_items;

      while (stim_items - directed_items < RANDOM_ITEMS) gen_url();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() > 0 || req_if.valid) @(posedge clock);
      while (expected_tags.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Tagged %0d URLs from %0d input items, %0d result items checked in %0d cycles.",
               urls_ended, stim_items, tags_checked, cycle_count);
      $display("Endings: %0d clean, %0d empty, %0d without delimiter; %0d mismatches.",
               err_hits[ERR_NONE], err_hits[ERR_EMPTY], err_hits[ERR_NO_DELIM], mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
